FILE: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, quiet while reset is held.
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/pd_pkg.sv
`default_nettype none

package pd_pkg;

    // Parser phases
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_TYPE_HI = 3'd2;
    localparam logic [2:0] PH_TYPE_LO = 3'd3;
    localparam logic [2:0] PH_DATA    = 3'd4;
    localparam logic [2:0] PH_FOOTER  = 3'd5;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_PAYLOAD    = 2'd0;
    localparam t_kind KIND_ACCEPT     = 2'd1;
    localparam t_kind KIND_BAD_FOOTER = 2'd2;
    localparam t_kind KIND_TOO_LONG   = 2'd3;

    typedef logic [1:0] t_cfg_index;

    localparam t_cfg_index REG_HEADER_MARK = 2'd0;
    localparam t_cfg_index REG_FOOTER_MARK = 2'd1;
    localparam t_cfg_index REG_MAX_LENGTH  = 2'd2;

    localparam logic [7:0] RST_HEADER_MARK = 8'hFE;
    localparam logic [7:0] RST_FOOTER_MARK = 8'hFD;
    localparam logic [7:0] RST_MAX_LENGTH  = 8'd250;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [15:0] frame_type;
        logic [7:0]  frame_length;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/packet_deframer.sv
`default_nettype none

// Byte-stream frame finder. Each push delivers one received byte; the block
// looks for frames of the form header mark, length byte, type word (high
// byte first), that many payload bytes, footer mark. Every payload byte comes
// out as a result with its index, frame type and declared length; the footer
// byte yields a frame-accepted or bad-footer result, and a length byte above
// max_length yields a length-rejected result. Bytes outside a frame give no
// result. The parser takes one byte every cycle while full is low and writes
// at most one result into a four-entry queue; an output register drains that
// queue. A result goes through the queue and then the output register to the
// output ports, and the sustained rate is one byte per cycle as long as
// results are popped; full rises only when all four queue entries hold unread
// results, so a stalled reader throttles the writer. The three registers
// (header mark, footer mark, max length) reset to 0xFE, 0xFD and 250 and
// should be written only while no transaction is in flight.
module packet_deframer (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // configuration
    input  wire                 i_cfg_wr_en,
    input  pd_pkg::t_cfg_index  i_cfg_index,
    input  wire  [7:0]          i_cfg_wdata,
    // byte input
    input  wire                 push,
    output logic                full,
    input  wire  [7:0]          i_rx_byte,
    // results
    output logic                empty,
    input  wire                 pop,
    output pd_pkg::t_kind       o_result_kind,
    output logic [7:0]          o_payload_byte,
    output logic [7:0]          o_payload_index,
    output logic [15:0]         o_frame_type,
    output logic [7:0]          o_frame_length
);
    import pd_pkg::*;

    logic    in_take;
    logic    res_valid;
    t_result res;
    logic    q_empty;
    logic    q_pop;
    t_result q_data;
    t_result out_res;

    // Accept a byte only while the queue has room for its result.
    assign in_take = push && !full;

    // Front: phase tracking and classification of each byte.
    pd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (in_take),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Decoupling queue between parser and output side.
    pd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    // Back: output register presented to the reader.
    pd_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_res     (out_res)
    );

    assign o_result_kind   = out_res.kind;
    assign o_payload_byte  = out_res.payload_byte;
    assign o_payload_index = out_res.payload_index;
    assign o_frame_type    = out_res.frame_type;
    assign o_frame_length  = out_res.frame_length;

endmodule

`default_nettype wire

FILE: sv/pd_parser.sv
`default_nettype none

module pd_parser (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_wr_en,
    input  pd_pkg::t_cfg_index   i_cfg_index,
    input  wire  [7:0]           i_cfg_wdata,
    input  wire                  i_valid,
    input  wire  [7:0]           i_rx_byte,
    output logic                 o_res_valid,
    output pd_pkg::t_result      o_res
);
    import pd_pkg::*;

    logic [7:0]  r_header_mark;
    logic [7:0]  r_footer_mark;
    logic [7:0]  r_max_length;
    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_cnt, n_cnt;
    logic [15:0] r_type, n_type;
    logic [7:0]  cnt_inc;

    assign cnt_inc = r_cnt + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_mark <= RST_HEADER_MARK;
            r_footer_mark <= RST_FOOTER_MARK;
            r_max_length  <= RST_MAX_LENGTH;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_HEADER_MARK: r_header_mark <= i_cfg_wdata;
                REG_FOOTER_MARK: r_footer_mark <= i_cfg_wdata;
                REG_MAX_LENGTH:  r_max_length  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_type      = r_type;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_valid) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (i_rx_byte == r_header_mark) begin
                        n_phase = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    if (i_rx_byte > r_max_length) begin
                        o_res_valid        = 1'b1;
                        o_res.kind         = KIND_TOO_LONG;
                        o_res.frame_length = i_rx_byte;
                        n_phase            = PH_HEADER;
                    end else begin
                        n_len   = i_rx_byte;
                        n_cnt   = 8'd0;
                        n_phase = PH_TYPE_HI;
                    end
                end
                PH_TYPE_HI: begin
                    n_type  = {8'd0, i_rx_byte};
                    n_phase = PH_TYPE_LO;
                end
                PH_TYPE_LO: begin
                    n_type  = {r_type[7:0], i_rx_byte};
                    n_phase = (r_len != 8'd0) ? PH_DATA : PH_FOOTER;
                end
                PH_DATA: begin
                    o_res_valid         = 1'b1;
                    o_res.kind          = KIND_PAYLOAD;
                    o_res.payload_byte  = i_rx_byte;
                    o_res.payload_index = r_cnt;
                    o_res.frame_type    = r_type;
                    o_res.frame_length  = r_len;
                    n_cnt               = cnt_inc;
                    if (cnt_inc == r_len) begin
                        n_phase = PH_FOOTER;
                    end
                end
                PH_FOOTER: begin
                    o_res_valid        = 1'b1;
                    o_res.kind         = (i_rx_byte == r_footer_mark) ? KIND_ACCEPT
                                                                      : KIND_BAD_FOOTER;
                    o_res.frame_type   = r_type;
                    o_res.frame_length = r_len;
                    n_phase            = PH_HEADER;
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_len   <= 8'd0;
            r_cnt   <= 8'd0;
            r_type  <= 16'd0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_type  <= n_type;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pd_fifo.sv
`default_nettype none

module pd_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  pd_pkg::t_result  i_data,
    output logic             o_full,
    input  wire              i_pop,
    output pd_pkg::t_result  o_data,
    output logic             o_empty
);
    import pd_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_AW:0]     r_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/pd_out.sv
`default_nettype none

module pd_out (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_q_empty,
    input  pd_pkg::t_result  i_q_data,
    output logic             o_q_pop,
    output logic             o_empty,
    input  wire              i_pop,
    output pd_pkg::t_result  o_res
);
    import pd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Refill the output register whenever it is free or being drained.
    assign o_q_pop = !i_q_empty && (!r_valid || i_pop);
    assign o_empty = !r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= i_q_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pd_checker.sv
`default_nettype none

`include "assert_macros.svh"

module pd_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_wr_en,
    input  pd_pkg::t_cfg_index  i_cfg_index,
    input  wire  [7:0]          i_cfg_wdata,
    input  wire                 push,
    input  wire                 full,
    input  wire  [7:0]          i_rx_byte,
    input  wire                 empty,
    input  wire                 pop,
    input  pd_pkg::t_kind       o_result_kind,
    input  wire  [7:0]          o_payload_byte,
    input  wire  [7:0]          o_payload_index,
    input  wire  [15:0]         o_frame_type,
    input  wire  [7:0]          o_frame_length
);
    import pd_pkg::*;

    `ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (empty && !full), "reset left data or full")
    `ASSERT_SYNC(a_stall_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_result_kind) && $stable(o_frame_type) && $stable(o_payload_byte)), "stalled result changed")
    `ASSERT_SYNC(a_index_in_frame, i_clk, i_rst_n, (!empty && o_result_kind == KIND_PAYLOAD) |-> (o_payload_index < o_frame_length), "payload index beyond length")
    `ASSERT_SYNC(a_status_no_data, i_clk, i_rst_n, (!empty && o_result_kind != KIND_PAYLOAD) |-> (o_payload_byte == 8'd0 && o_payload_index == 8'd0), "status carries payload")
    `ASSERT_SYNC(a_reject_no_type, i_clk, i_rst_n, (!empty && o_result_kind == KIND_TOO_LONG) |-> (o_frame_type == 16'd0), "rejected frame carries type")

endmodule

bind packet_deframer pd_checker u_pd_checker (.*);

`default_nettype wire
